// ===== design/rbro_pkg.sv =====
// Shared types and constants of the rectangle blitter.
package rbro_pkg;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_WRITTEN = 2'd0,
      ST_OUTSIDE = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_READ    = 2'd3
   } rbro_status_type;

   // Request kinds carried in req_tuser.
   localparam logic REQ_BLIT = 1'b0;
   localparam logic REQ_READ = 1'b1;

   // Raster operations; the unused code behaves as copy.
   localparam logic [1:0] MODE_COPY = 2'd0;
   localparam logic [1:0] MODE_OR   = 2'd1;
   localparam logic [1:0] MODE_MASK = 2'd2;

   // Register indexes of the configuration port.
   localparam logic [2:0] REG_X_START     = 3'd0;
   localparam logic [2:0] REG_Y_START     = 3'd1;
   localparam logic [2:0] REG_RECT_WIDTH  = 3'd2;
   localparam logic [2:0] REG_RECT_HEIGHT = 3'd3;
   localparam logic [2:0] REG_FILL_MODE   = 3'd4;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 11;
   localparam int TDATA_W     = 48;
   localparam int COORD_W     = 10;
   localparam int PIXEL_W     = 24;
   // Address width wide enough for the largest screen.
   localparam int FULL_ADDR_W = 20;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   // One classified request as it travels from front to back.
   typedef struct packed {
      rbro_status_type      status;
      logic                 last;
      logic [COORD_W-1:0]   col;
      logic [COORD_W-1:0]   row;
      logic [PIXEL_W-1:0]   rgb;
      logic [1:0]           mode;
   } rbro_item_type;

endpackage

// ===== design/rbro_front.sv =====
// Front end: configuration registers, raster cursor and request classification.
module rbro_front #(
   parameter int SCREEN_COLS = 128,
   parameter int SCREEN_ROWS = 128,
   parameter int AW          = 14
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wen,
   input  logic [rbro_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rbro_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic                                req_tuser,
   input  logic [rbro_pkg::TDATA_W-1:0]        req_tdata,
   input  logic                                q_full,
   input  logic                                clearing,
   output logic                                push,
   output rbro_pkg::rbro_item_type             push_item,
   output logic [AW-1:0]                       push_addr
);
   import rbro_pkg::*;

   localparam logic [10:0] COLS_L = 11'(SCREEN_COLS);
   localparam logic [10:0] ROWS_L = 11'(SCREEN_ROWS);

   logic [9:0]    x_start_ff, x_start_in;
   logic [9:0]    y_start_ff, y_start_in;
   logic [10:0]   width_ff, width_in;
   logic [10:0]   height_ff, height_in;
   logic [1:0]    mode_ff, mode_in;
   logic [AW-1:0] y_base_ff, y_base_in;
   logic [AW-1:0] line_addr_ff, line_addr_in;
   logic [9:0]    cur_col_ff, cur_col_in;
   logic [9:0]    cur_row_ff, cur_row_in;

   logic [10:0]   x_end, y_end;
   logic          outside, empty_rect;
   logic [9:0]    blit_col, blit_row;
   logic          col_wrap, row_wrap;
   logic [9:0]    read_col, read_row;
   logic          read_oob;
   logic [FULL_ADDR_W-1:0] read_addr_full;
   logic [AW-1:0] y_base_new;
   logic          accept, blit_go;

   assign read_col = req_tdata[33:24];
   assign read_row = req_tdata[43:34];

   assign req_tready = !q_full && !clearing;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept;

   // End coordinates in 11 bits; a start plus width above 2047 still wraps.
   assign x_end      = {1'b0, x_start_ff} + width_ff;
   assign y_end      = {1'b0, y_start_ff} + height_ff;
   assign outside    = ({1'b0, x_start_ff} >= COLS_L) || (x_end > COLS_L) ||
                       ({1'b0, y_start_ff} >= ROWS_L) || (y_end > ROWS_L);
   assign empty_rect = (width_ff == 11'd0) || (height_ff == 11'd0);

   assign blit_col = x_start_ff + cur_col_ff;
   assign blit_row = y_start_ff + cur_row_ff;
   assign col_wrap = ({1'b0, cur_col_ff} + 11'd1) >= width_ff;
   assign row_wrap = ({1'b0, cur_row_ff} + 11'd1) >= height_ff;

   assign read_oob = ({1'b0, read_col} >= COLS_L) || ({1'b0, read_row} >= ROWS_L);
   assign read_addr_full = FULL_ADDR_W'(read_row) * FULL_ADDR_W'(SCREEN_COLS) +
                           FULL_ADDR_W'(read_col);

   assign y_base_new = AW'(FULL_ADDR_W'(csr_wdata[9:0]) * FULL_ADDR_W'(SCREEN_COLS));

   assign blit_go = accept && (req_tuser == REQ_BLIT) && !outside && !empty_rect;

   // Classify the request.
   always_comb begin
      push_item      = '0;
      push_item.mode = mode_ff;
      push_addr      = '0;
      if (req_tuser == REQ_READ) begin
         push_item.col = read_col;
         push_item.row = read_row;
         if (read_oob) begin
            push_item.status = ST_OUTSIDE;
         end else begin
            push_item.status = ST_READ;
            push_addr        = AW'(read_addr_full);
         end
      end else if (outside) begin
         push_item.status = ST_OUTSIDE;
      end else if (empty_rect) begin
         push_item.status = ST_EMPTY;
      end else begin
         push_item.status = ST_WRITTEN;
         push_item.col    = blit_col;
         push_item.row    = blit_row;
         push_item.rgb    = {req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]};
         push_item.last   = col_wrap && row_wrap;
         push_addr        = line_addr_ff + AW'(blit_col);
      end
   end

   // Register writes and cursor movement.
   always_comb begin
      x_start_in   = x_start_ff;
      y_start_in   = y_start_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      mode_in      = mode_ff;
      y_base_in    = y_base_ff;
      line_addr_in = line_addr_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      if (csr_wen) begin
         case (csr_index)
            REG_X_START:     x_start_in = csr_wdata[9:0];
            REG_Y_START: begin
               y_start_in = csr_wdata[9:0];
               y_base_in  = y_base_new;
            end
            REG_RECT_WIDTH:  width_in  = csr_wdata;
            REG_RECT_HEIGHT: height_in = csr_wdata;
            REG_FILL_MODE:   mode_in   = csr_wdata[1:0];
            default: ;
         endcase
         if (csr_index inside {REG_X_START, REG_Y_START, REG_RECT_WIDTH,
                               REG_RECT_HEIGHT, REG_FILL_MODE}) begin
            cur_col_in   = '0;
            cur_row_in   = '0;
            line_addr_in = y_base_in;
         end
      end else if (blit_go) begin
         if (col_wrap) begin
            cur_col_in = '0;
            if (row_wrap) begin
               cur_row_in   = '0;
               line_addr_in = y_base_ff;
            end else begin
               cur_row_in   = cur_row_ff + 10'd1;
               line_addr_in = line_addr_ff + AW'(SCREEN_COLS);
            end
         end else begin
            cur_col_in = cur_col_ff + 10'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_start_ff   <= '0;
         y_start_ff   <= '0;
         width_ff     <= '0;
         height_ff    <= '0;
         mode_ff      <= MODE_COPY;
         y_base_ff    <= '0;
         line_addr_ff <= '0;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
      end else begin
         x_start_ff   <= x_start_in;
         y_start_ff   <= y_start_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         mode_ff      <= mode_in;
         y_base_ff    <= y_base_in;
         line_addr_ff <= line_addr_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
      end
   end

endmodule

// ===== design/rbro_queue.sv =====
// Short queue of classified requests between front and back.
module rbro_queue #(
   parameter int AW = 14
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  rbro_pkg::rbro_item_type push_item,
   input  logic [AW-1:0]           push_addr,
   output logic                    full,
   input  logic                    pop,
   output logic                    head_valid,
   output rbro_pkg::rbro_item_type head_item,
   output logic [AW-1:0]           head_addr
);
   import rbro_pkg::*;

   rbro_item_type          item_ff [QUEUE_DEPTH];
   logic [AW-1:0]          addr_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;

   assign full       = count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_item  = item_ff[rd_ptr_ff];
   assign head_addr  = addr_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QUEUE_PTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QUEUE_PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         item_ff[wr_ptr_ff] <= push_item;
         addr_ff[wr_ptr_ff] <= push_addr;
      end
   end

endmodule

// ===== design/rbro_back.sv =====
// Back end: frame store with its clearing pass, read-modify-write pipeline and result register.
module rbro_back #(
   parameter int DEPTH = 16384,
   parameter int AW    = 14
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             head_valid,
   input  rbro_pkg::rbro_item_type          head_item,
   input  logic [AW-1:0]                    head_addr,
   output logic                             pop,
   output logic                             clearing,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [1:0]                       rsp_tuser,
   output logic [rbro_pkg::TDATA_W-1:0]     rsp_tdata,
   output logic                             rsp_tlast
);
   import rbro_pkg::*;

   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   logic [PIXEL_W-1:0] mem [DEPTH];

   logic               clearing_ff, clearing_in;
   logic [AW-1:0]      clr_addr_ff, clr_addr_in;

   logic               d_valid_ff, d_valid_in;
   rbro_item_type      d_item_ff;
   logic [AW-1:0]      d_addr_ff;
   logic [PIXEL_W-1:0] rdata_ff;
   logic               fwd_hit_ff;
   logic [PIXEL_W-1:0] fwd_data_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff;
   logic [TDATA_W-1:0] rsp_data_ff;
   logic               rsp_last_ff;

   logic               out_free, d_adv, d_free, d_write;
   logic [PIXEL_W-1:0] stored, d_value;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [PIXEL_W-1:0] mem_wdata;

   assign clearing = clearing_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign d_adv    = d_valid_ff && out_free;
   assign d_free   = !d_valid_ff || out_free;
   assign pop      = head_valid && d_free;

   // A write that lands in the same cycle as the read of the same pixel is forwarded.
   assign stored = fwd_hit_ff ? fwd_data_ff : rdata_ff;

   always_comb begin
      case (d_item_ff.status)
         ST_WRITTEN: begin
            case (d_item_ff.mode)
               MODE_OR:   d_value = stored | d_item_ff.rgb;
               MODE_MASK: d_value = stored & d_item_ff.rgb;
               default:   d_value = d_item_ff.rgb;
            endcase
         end
         ST_READ:  d_value = stored;
         default:  d_value = d_item_ff.rgb;
      endcase
   end

   assign d_write   = d_adv && (d_item_ff.status == ST_WRITTEN);
   assign mem_we    = clearing_ff || d_write;
   assign mem_waddr = clearing_ff ? clr_addr_ff : d_addr_ff;
   assign mem_wdata = clearing_ff ? '0 : d_value;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (pop) begin
         rdata_ff <= mem[head_addr];
      end
   end

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == LAST_ADDR) begin
            clearing_in = 1'b0;
         end
      end
      d_valid_in = pop ? 1'b1 : (d_adv ? 1'b0 : d_valid_ff);
      rsp_valid_in = d_adv ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         d_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clearing_ff  <= clearing_in;
         clr_addr_ff  <= clr_addr_in;
         d_valid_ff   <= d_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         d_item_ff   <= head_item;
         d_addr_ff   <= head_addr;
         fwd_hit_ff  <= d_write && (d_addr_ff == head_addr);
         fwd_data_ff <= d_value;
      end
      if (d_adv) begin
         rsp_status_ff <= d_item_ff.status;
         rsp_last_ff   <= d_item_ff.last;
         rsp_data_ff   <= {4'b0000, d_value[7:0], d_value[15:8], d_value[23:16],
                           d_item_ff.row, d_item_ff.col};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== design/rect_blit_raster_op.sv =====
// Top level of the rectangle blitter with raster operations.
// An accepted request passes through the queue, the read stage and the result register.
// Throughput: one request per cycle while rsp_tready is high, set by the single
// read-modify-write pass through the frame store, with the write of one pixel
// forwarded to the read of the next. Reset is synchronous and active high; after it
// a clearing pass zeroes the frame store, one pixel per cycle, with req_tready low.
module rect_blit_raster_op #(
   parameter int SCREEN_COLS = 128,
   parameter int SCREEN_ROWS = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wen,
   input  logic [rbro_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rbro_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic                              req_tuser,  // req_type
   // src_red, src_green, src_blue, read_col, read_row, zero pad
   input  logic [rbro_pkg::TDATA_W-1:0]      req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [1:0]                        rsp_tuser,  // status
   // pix_col, pix_row, out_red, out_green, out_blue, zero pad
   output logic [rbro_pkg::TDATA_W-1:0]      rsp_tdata,
   output logic                              rsp_tlast   // last_pixel
);
   import rbro_pkg::*;

   localparam int DEPTH = SCREEN_COLS * SCREEN_ROWS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic          push, pop, q_full, head_valid, clearing;
   rbro_item_type push_item, head_item;
   logic [AW-1:0] push_addr, head_addr;

   rbro_front #(
      .SCREEN_COLS (SCREEN_COLS),
      .SCREEN_ROWS (SCREEN_ROWS),
      .AW          (AW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .clearing   (clearing),
      .push       (push),
      .push_item  (push_item),
      .push_addr  (push_addr)
   );

   rbro_queue #(
      .AW (AW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .push_addr  (push_addr),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_addr  (head_addr)
   );

   rbro_back #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_addr  (head_addr),
      .pop        (pop),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== design/rbro_checker.sv =====
// Port-level checks of the rectangle blitter and their binding to the top level.
module rbro_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [1:0]                    rsp_tuser,
   input  logic [rbro_pkg::TDATA_W-1:0]  rsp_tdata,
   input  logic                          rsp_tlast
);
   import rbro_pkg::*;

   // The frame store is being cleared straight after reset, so no request is taken.
   a_no_request_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("request taken or result shown straight after reset");

   // Only a written pixel can complete the rectangle.
   a_last_only_on_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tuser == ST_WRITTEN))
      else $error("last pixel flagged on a result that wrote nothing");

   // Error results carry no colour, and an empty rectangle carries nothing at all.
   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == ST_OUTSIDE || rsp_tuser == ST_EMPTY)) |->
      (rsp_tdata[43:20] == '0) && ((rsp_tuser == ST_OUTSIDE) || (rsp_tdata == '0)))
      else $error("error result carries pixel data");

   // A result that is not taken stays as it is.
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
      (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("stalled result changed");

   // While a request waits, ready is always at a known level.
   a_request_ready_known: assert property (@(posedge clock) disable iff (reset)
      req_tvalid |-> !$isunknown(req_tready))
      else $error("request ready unknown");

endmodule

bind rect_blit_raster_op rbro_checker u_rbro_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
